>>> rtl/assert_macros.svh
// Assertion helpers for the bound checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BTC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define BTC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/btc_pkg.sv
`default_nettype none
package btc_pkg;

   typedef enum logic [1:0] {
      CMD_BOTH  = 2'd0,
      CMD_TEMP  = 2'd1,
      CMD_PRESS = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_TEMP    = 2'd0,
      REG_PRESS_A = 2'd1,
      REG_PRESS_B = 2'd2,
      REG_PRESS_9 = 2'd3
   } reg_type;

   typedef enum logic [3:0] {
      ST_T0  = 4'd0,
      ST_T1  = 4'd1,
      ST_T2  = 4'd2,
      ST_P0  = 4'd3,
      ST_P1  = 4'd4,
      ST_P2  = 4'd5,
      ST_P3  = 4'd6,
      ST_P4  = 4'd7,
      ST_P5  = 4'd8,
      ST_P6  = 4'd9,
      ST_PD  = 4'd10,
      ST_P7  = 4'd11,
      ST_P8  = 4'd12,
      ST_P9  = 4'd13,
      ST_FIN = 4'd14
   } step_type;

   typedef struct packed {
      logic     load;
      logic     mul_go;
      logic     div_go;
      logic     finish;
      step_type step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
      logic div_zero;
   } dp_sts_type;

   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] ADC_FULL    = 64'd1048576;
   localparam logic [63:0] SCALE_3125  = 64'd3125;
   localparam logic [63:0] ROUND_128   = 64'd128;
   localparam logic [63:0] ONE_47      = 64'd1 << 47;
   localparam logic [63:0] FINE_MIN    = 64'hFFFF_FFFF_8000_0000;
   localparam logic [63:0] FINE_MAX    = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] TEMP_MIN    = 64'hFFFF_FFFF_FF80_0000;
   localparam logic [63:0] TEMP_MAX    = 64'h0000_0000_007F_FFFF;

   function automatic logic [63:0] sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

   function automatic logic [63:0] asr(input logic [63:0] v, input int n);
      return 64'($signed(v) >>> n);
   endfunction

   function automatic logic [31:0] sat_fine(input logic [63:0] f);
      if ($signed(f) < $signed(FINE_MIN)) begin
         return FINE_MIN[31:0];
      end else if ($signed(f) > $signed(FINE_MAX)) begin
         return FINE_MAX[31:0];
      end
      return f[31:0];
   endfunction

   function automatic logic [23:0] centi_from_fine(input logic [31:0] fine);
      logic [63:0] w;
      logic [63:0] t;
      w = {{32{fine[31]}}, fine};
      t = asr((w << 2) + w + ROUND_128, 8);
      if ($signed(t) < $signed(TEMP_MIN)) begin
         return TEMP_MIN[23:0];
      end else if ($signed(t) > $signed(TEMP_MAX)) begin
         return TEMP_MAX[23:0];
      end
      return t[23:0];
   endfunction

endpackage
`default_nettype wire

>>> rtl/btc_if.sv
`default_nettype none
interface btc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [19:0] raw_temperature;
   logic [19:0] raw_pressure;
   modport source (output valid, cmd, raw_temperature, raw_pressure, input ready);
   modport sink (input valid, cmd, raw_temperature, raw_pressure, output ready);
endinterface

interface btc_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] temperature_centi;
   logic [31:0] pressure_q24_8;
   logic        divide_by_zero;
   modport source (output valid, temperature_centi, pressure_q24_8, divide_by_zero,
                   input ready);
   modport sink (input valid, temperature_centi, pressure_q24_8, divide_by_zero,
                 output ready);
endinterface

interface btc_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/btc_mul.sv
`default_nettype none
module btc_mul (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] op_a,
   input  wire  [63:0] op_b,
   output logic        done,
   output logic [63:0] product
);
   logic        busy_ff, busy_in;
   logic [63:0] a_ff, a_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] acc_ff, acc_in;

   assign done    = busy_ff && (a_ff == 64'd0);
   assign product = acc_ff;

   // shift-add, one multiplier bit per cycle, product modulo 2^64
   always_comb begin
      busy_in = busy_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         a_in    = op_a;
         b_in    = op_b;
         acc_in  = 64'd0;
      end else if (busy_ff) begin
         if (a_ff == 64'd0) begin
            busy_in = 1'b0;
         end else begin
            acc_in = a_ff[0] ? acc_ff + b_ff : acc_ff;
            a_in   = a_ff >> 1;
            b_in   = b_ff << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end
endmodule
`default_nettype wire

>>> rtl/btc_div.sv
`default_nettype none
module btc_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [63:0] dividend,
   input  wire  [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [63:0] den_ff, den_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [64:0] trial;

   assign done     = busy_ff && (cnt_ff == 7'd0);
   assign quotient = neg_ff ? 64'd0 - quo_ff : quo_ff;
   assign trial    = {1'b0, rem_ff[62:0], quo_ff[63]} - {1'b0, den_ff};

   // restoring division on magnitudes, one quotient bit per cycle
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 7'd64;
         neg_in  = dividend[63] ^ divisor[63];
         den_in  = divisor[63] ? 64'd0 - divisor : divisor;
         rem_in  = 64'd0;
         quo_in  = dividend[63] ? 64'd0 - dividend : dividend;
      end else if (busy_ff) begin
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 7'd1;
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], quo_ff[63]};
               quo_in = {quo_ff[62:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end
endmodule
`default_nettype wire

>>> rtl/btc_ctrl.sv
`default_nettype none
module btc_ctrl
   import btc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   input  wire   [1:0]  req_cmd,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire          rsp_ready,
   output ctrl_cmd_type ctrl,
   input  dp_sts_type   sts
);
   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_ISSUE  = 5'b00010,
      S_WAIT   = 5'b00100,
      S_DECIDE = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   cmd_type   cmd_ff, cmd_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctrl         = '0;
      ctrl.step    = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               cmd_in    = cmd_type'(req_cmd);
               state_in  = S_ISSUE;
               unique case (cmd_type'(req_cmd))
                  CMD_BOTH, CMD_TEMP: step_in = ST_T0;
                  CMD_PRESS:          step_in = ST_P0;
                  default:            step_in = ST_FIN;
               endcase
            end
         end
         S_ISSUE: begin
            if (step_ff == ST_FIN) begin
               state_in = S_FINISH;
            end else begin
               ctrl.div_go = (step_ff == ST_PD);
               ctrl.mul_go = (step_ff != ST_PD);
               state_in    = S_WAIT;
            end
         end
         S_WAIT: begin
            if (sts.done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_ISSUE;
            if ((step_ff == ST_T2 && cmd_ff == CMD_TEMP) ||
                (step_ff == ST_P5 && sts.div_zero) || step_ff == ST_P9) begin
               step_in = ST_FIN;
            end else begin
               step_in = step_type'(step_ff + 4'd1);
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.finish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      cmd_ff  <= cmd_in;
   end
endmodule
`default_nettype wire

>>> rtl/btc_dp.sv
`default_nettype none
module btc_dp
   import btc_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire   [19:0] req_raw_temperature,
   input  wire   [19:0] req_raw_pressure,
   input  wire          csr_write,
   input  wire   [1:0]  csr_index,
   input  wire   [63:0] csr_data,
   input  ctrl_cmd_type ctrl,
   output dp_sts_type   sts,
   output logic  [23:0] rsp_temperature_centi,
   output logic  [31:0] rsp_pressure_q24_8,
   output logic         rsp_divide_by_zero
);
   logic [47:0] tco_ff;
   logic [63:0] pca_ff, pcb_ff;
   logic [15:0] p9_ff;
   logic [31:0] fine_ff, fine_in;
   logic [19:0] rt_ff, rp_ff;
   logic [63:0] v1_ff, v1_in, v2_ff, v2_in, x_ff, x_in, p_ff, p_in;
   logic [23:0] temp_ff, temp_in;
   logic        dz_ff, dz_in, pok_ff, pok_in;
   logic [23:0] out_t_ff;
   logic [31:0] out_p_ff;
   logic        out_dz_ff;

   logic [63:0] op_a, op_b, prod, quo, vp, t_v1, fin_sum, fin_p;
   logic        mul_done, div_done, done;

   btc_mul u_mul (
      .clock(clock), .reset(reset), .start(ctrl.mul_go),
      .op_a(op_a), .op_b(op_b), .done(mul_done), .product(prod)
   );

   btc_div u_div (
      .clock(clock), .reset(reset), .start(ctrl.div_go),
      .dividend(x_ff), .divisor(v1_ff), .done(div_done), .quotient(quo)
   );

   assign done         = mul_done || div_done;
   assign sts.done     = done;
   assign sts.div_zero = dz_ff;

   assign vp      = {{32{fine_ff[31]}}, fine_ff} - FINE_OFFSET;
   assign t_v1    = asr(prod, 33);
   assign fin_sum = p_ff + v1_ff + v2_ff;
   assign fin_p   = asr(fin_sum, 8) + (sx16(pcb_ff[47:32]) << 4);

   always_comb begin
      op_a = 64'd0;
      op_b = 64'd0;
      case (ctrl.step)
         ST_T0: begin
            op_a = {47'd0, rt_ff[19:3]} - {47'd0, tco_ff[15:0], 1'b0};
            op_b = sx16(tco_ff[31:16]);
         end
         ST_T1: begin
            op_a = {48'd0, rt_ff[19:4]} - {48'd0, tco_ff[15:0]};
            op_b = op_a;
         end
         ST_T2: begin op_a = x_ff;  op_b = sx16(tco_ff[47:32]); end
         ST_P0: begin op_a = vp;    op_b = vp;                  end
         ST_P1: begin op_a = x_ff;  op_b = sx16(pcb_ff[31:16]); end
         ST_P2: begin op_a = vp;    op_b = sx16(pcb_ff[15:0]);  end
         ST_P3: begin op_a = x_ff;  op_b = sx16(pca_ff[47:32]); end
         ST_P4: begin op_a = vp;    op_b = sx16(pca_ff[31:16]); end
         ST_P5: begin op_a = ONE_47 + v1_ff; op_b = {48'd0, pca_ff[15:0]}; end
         ST_P6: begin
            op_a = ((ADC_FULL - {44'd0, rp_ff}) << 31) - v2_ff;
            op_b = SCALE_3125;
         end
         ST_P7: begin op_a = sx16(p9_ff); op_b = asr(p_ff, 13); end
         ST_P8: begin op_a = x_ff;        op_b = asr(p_ff, 13); end
         ST_P9: begin op_a = sx16(pcb_ff[63:48]); op_b = p_ff; end
         default: ;
      endcase
   end

   always_comb begin
      fine_in = fine_ff;
      v1_in   = v1_ff;
      v2_in   = v2_ff;
      x_in    = x_ff;
      p_in    = p_ff;
      temp_in = temp_ff;
      dz_in   = dz_ff;
      pok_in  = pok_ff;
      if (ctrl.load) begin
         temp_in = 24'd0;
         dz_in   = 1'b0;
         pok_in  = 1'b0;
      end else if (done) begin
         case (ctrl.step)
            ST_T0: v1_in = asr(prod, 11);
            ST_T1: x_in  = asr(prod, 12);
            ST_T2: begin
               fine_in = sat_fine(v1_ff + asr(prod, 14));
               temp_in = centi_from_fine(fine_in);
            end
            ST_P0: x_in  = prod;
            ST_P1: v2_in = prod;
            ST_P2: v2_in = v2_ff + (prod << 17) + (sx16(pca_ff[63:48]) << 35);
            ST_P3: v1_in = asr(prod, 8);
            ST_P4: v1_in = v1_ff + (prod << 12);
            ST_P5: begin
               v1_in = t_v1;
               dz_in = (t_v1 == 64'd0);
            end
            ST_P6: x_in  = prod;
            ST_PD: p_in  = quo;
            ST_P7: x_in  = prod;
            ST_P8: v1_in = asr(prod, 25);
            ST_P9: begin
               v2_in  = asr(prod, 19);
               pok_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tco_ff  <= 48'd0;
         pca_ff  <= 64'd0;
         pcb_ff  <= 64'd0;
         p9_ff   <= 16'd0;
         fine_ff <= 32'd0;
      end else begin
         fine_ff <= fine_in;
         if (csr_write) begin
            unique case (reg_type'(csr_index))
               REG_TEMP:    tco_ff <= csr_data[47:0];
               REG_PRESS_A: pca_ff <= csr_data;
               REG_PRESS_B: pcb_ff <= csr_data;
               REG_PRESS_9: p9_ff  <= csr_data[15:0];
               default: ;
            endcase
         end
      end
      if (ctrl.load) begin
         rt_ff <= req_raw_temperature;
         rp_ff <= req_raw_pressure;
      end
      v1_ff   <= v1_in;
      v2_ff   <= v2_in;
      x_ff    <= x_in;
      p_ff    <= p_in;
      temp_ff <= temp_in;
      dz_ff   <= dz_in;
      pok_ff  <= pok_in;
      if (ctrl.finish) begin
         out_t_ff  <= temp_ff;
         out_p_ff  <= pok_ff ? fin_p[31:0] : 32'd0;
         out_dz_ff <= dz_ff;
      end
   end

   assign rsp_temperature_centi = out_t_ff;
   assign rsp_pressure_q24_8    = out_p_ff;
   assign rsp_divide_by_zero    = out_dz_ff;
endmodule
`default_nettype wire

>>> rtl/baro_temp_compensation.sv
// Barometer temperature/pressure compensation with 64-bit integer math.
// req_chan carries cmd (both, temperature only, pressure only, none) and
// the two raw 20-bit conversions; rsp_chan returns one beat per request
// beat with temperature in 0.01 degC, pressure in Q24.8 Pa and a
// divide-by-zero flag. csr_chan writes the calibration registers by
// index and is always ready. The user must see that it is written only
// while the block is idle; the block does not enforce this. One request
// is in work at a time. All math runs on one shift-add 64-bit multiplier
// and one radix-2 divider. Temperature only: 3 products. Pressure only:
// 10 products plus the divide. Early multiplier termination on small
// operands shortens a product.
// The result beat sits in an output register; a new request is taken while
// it waits, and a finished result waits in place until the receiver takes it.
// Reset clears coefficients and stored fine temperature to zero and drops
// rsp valid.
`default_nettype none
module baro_temp_compensation
   import btc_pkg::*;
(
   input  wire clock,
   input  wire reset,
   btc_req_if.sink   req_chan,
   btc_rsp_if.source rsp_chan,
   btc_csr_if.sink   csr_chan
);
   ctrl_cmd_type ctrl;
   dp_sts_type   sts;

   assign csr_chan.ready = 1'b1;

   btc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_chan.valid), .req_cmd(req_chan.cmd), .req_ready(req_chan.ready),
      .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
      .ctrl(ctrl), .sts(sts)
   );

   btc_dp u_dp (
      .clock(clock), .reset(reset),
      .req_raw_temperature(req_chan.raw_temperature),
      .req_raw_pressure(req_chan.raw_pressure),
      .csr_write(csr_chan.valid), .csr_index(csr_chan.index), .csr_data(csr_chan.data),
      .ctrl(ctrl), .sts(sts),
      .rsp_temperature_centi(rsp_chan.temperature_centi),
      .rsp_pressure_q24_8(rsp_chan.pressure_q24_8),
      .rsp_divide_by_zero(rsp_chan.divide_by_zero)
   );
endmodule
`default_nettype wire

>>> rtl/btc_chk.sv
`default_nettype none
`include "assert_macros.svh"
module btc_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_pressure,
   input wire        rsp_dz
);
   `BTC_ASSERT_NEXT(a_reset_drops_rsp, clock, 1'b0, reset, !rsp_valid)
   `BTC_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)
   `BTC_ASSERT_SAME(a_dz_zero_press, clock, reset, rsp_valid && rsp_dz, rsp_pressure == 32'd0)
   `BTC_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind baro_temp_compensation btc_chk u_btc_chk (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_pressure(rsp_chan.pressure_q24_8), .rsp_dz(rsp_chan.divide_by_zero)
);
`default_nettype wire

>>> tb/sv/btc_compensation_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module btc_compensation_checker
   import btc_pkg::*;
(
   input  wire  clock,
   input  wire  reset,
   btc_req_if   req,
   btc_rsp_if   rsp,
   btc_csr_if   csr,
   output int   errors,
   output int   pending
);

   typedef struct packed {
      logic [23:0] temperature_centi;
      logic [31:0] pressure_q24_8;
      logic        divide_by_zero;
   } reading_type;

   logic [47:0] temp_cal;
   logic [63:0] press_cal_a;
   logic [63:0] press_cal_b;
   logic [15:0] press_cal_nine;
   logic [31:0] fine_temp;
   reading_type expected_readings[$];

   function automatic logic [63:0] ext16(input logic [63:0] v, input int pos);
      logic [15:0] s;
      s = v[pos +: 16];
      return {{48{s[15]}}, s};
   endfunction

   function automatic logic [63:0] shr_arith(input logic [63:0] v, input int n);
      return $signed(v) >>> n;
   endfunction

   function automatic logic [63:0] quotient_trunc(input logic [63:0] a,
                                                  input logic [63:0] b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] q;
      ma = a[63] ? -a : a;
      mb = b[63] ? -b : b;
      q = ma / mb;
      return (a[63] != b[63]) ? -q : q;
   endfunction

   function automatic void update_fine(input logic [19:0] raw_t);
      logic [63:0] adc;
      logic [63:0] t1;
      logic [63:0] v1;
      logic [63:0] d;
      logic [63:0] v2;
      logic [63:0] f;
      adc = {44'd0, raw_t};
      t1 = {48'd0, temp_cal[15:0]};
      v1 = shr_arith(((adc >> 3) - (t1 << 1)) * ext16({16'd0, temp_cal}, 16), 11);
      d = (adc >> 4) - t1;
      v2 = shr_arith(shr_arith(d * d, 12) * ext16({16'd0, temp_cal}, 32), 14);
      f = v1 + v2;
      if ($signed(f) < -64'sd2147483648) begin
         f = 64'hFFFF_FFFF_8000_0000;
      end else if ($signed(f) > 64'sd2147483647) begin
         f = 64'h7FFF_FFFF;
      end
      fine_temp = f[31:0];
   endfunction

   function automatic logic [23:0] centi_degrees();
      logic [63:0] w;
      w = shr_arith({{32{fine_temp[31]}}, fine_temp} * 64'd5 + 64'd128, 8);
      if ($signed(w) < -64'sd8388608) begin
         w = 64'hFFFF_FFFF_FF80_0000;
      end else if ($signed(w) > 64'sd8388607) begin
         w = 64'h7F_FFFF;
      end
      return w[23:0];
   endfunction

   function automatic void pressure_pa(input logic [19:0] raw_p,
                                       output logic [31:0] pa, output logic dz);
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] p;
      logic [63:0] p9;
      v1 = {{32{fine_temp[31]}}, fine_temp} - 64'd128000;
      v2 = v1 * v1 * ext16(press_cal_b, 16);
      v2 = v2 + ((v1 * ext16(press_cal_b, 0)) << 17);
      v2 = v2 + (ext16(press_cal_a, 48) << 35);
      v1 = shr_arith(v1 * v1 * ext16(press_cal_a, 32), 8)
           + ((v1 * ext16(press_cal_a, 16)) << 12);
      v1 = shr_arith(((64'd1 << 47) + v1) * {48'd0, press_cal_a[15:0]}, 33);
      if (v1 == 64'd0) begin
         pa = '0;
         dz = 1'b1;
         return;
      end
      p = 64'd1048576 - {44'd0, raw_p};
      p = quotient_trunc(((p << 31) - v2) * 64'd3125, v1);
      p9 = {{48{press_cal_nine[15]}}, press_cal_nine};
      v1 = shr_arith(p9 * shr_arith(p, 13) * shr_arith(p, 13), 25);
      v2 = shr_arith(ext16(press_cal_b, 48) * p, 19);
      p = shr_arith(p + v1 + v2, 8) + (ext16(press_cal_b, 32) << 4);
      pa = p[31:0];
      dz = 1'b0;
   endfunction

   function automatic reading_type compensate(input logic [1:0] cmd,
                                              input logic [19:0] raw_t,
                                              input logic [19:0] raw_p);
      reading_type r;
      r = '0;
      if (cmd == CMD_BOTH || cmd == CMD_TEMP) begin
         update_fine(raw_t);
         r.temperature_centi = centi_degrees();
      end
      if (cmd == CMD_BOTH || cmd == CMD_PRESS) begin
         pressure_pa(raw_p, r.pressure_q24_8, r.divide_by_zero);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      int bad;
      bad = 0;
      if (reset) begin
         temp_cal <= '0;
         press_cal_a <= '0;
         press_cal_b <= '0;
         press_cal_nine <= '0;
         fine_temp = '0;
         expected_readings.delete();
         errors <= 0;
         pending <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_TEMP: begin
                  temp_cal <= csr.data[47:0];
               end
               REG_PRESS_A: begin
                  press_cal_a <= csr.data;
               end
               REG_PRESS_B: begin
                  press_cal_b <= csr.data;
               end
               default: begin
                  press_cal_nine <= csr.data[15:0];
               end
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_readings.size() == 0) begin
               $error("result beat with no request pending");
               bad = bad + 1;
            end else begin
               want = expected_readings.pop_front();
               if (rsp.temperature_centi !== want.temperature_centi) begin
                  $error("temperature_centi: expected %0d actual %0d",
                         $signed(want.temperature_centi), $signed(rsp.temperature_centi));
                  bad = bad + 1;
               end
               if (rsp.pressure_q24_8 !== want.pressure_q24_8) begin
                  $error("pressure_q24_8: expected %0d actual %0d",
                         want.pressure_q24_8, rsp.pressure_q24_8);
                  bad = bad + 1;
               end
               if (rsp.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero: expected %0b actual %0b",
                         want.divide_by_zero, rsp.divide_by_zero);
                  bad = bad + 1;
               end
            end
         end
         if (req.valid && req.ready) begin
            expected_readings.push_back(compensate(req.cmd, req.raw_temperature,
                                                   req.raw_pressure));
         end
         errors <= errors + bad;
         pending <= expected_readings.size();
      end
   end

endmodule
`default_nettype wire

>>> tb/sv/tb_baro_temp_compensation.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_baro_temp_compensation;
   import btc_pkg::*;

   logic clock;
   logic reset;
   int   errors;
   int   pending;
   int   send_idle_pct;
   int   recv_stall_pct;

   btc_req_if req();
   btc_rsp_if rsp();
   btc_csr_if csr();

   baro_temp_compensation dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req),
      .rsp_chan(rsp),
      .csr_chan(csr)
   );

   btc_compensation_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .csr(csr),
      .errors(errors),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic write_reg(input reg_type idx, input logic [63:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
   endtask

   task automatic load_cal(input logic [47:0] t, input logic [63:0] a,
                           input logic [63:0] b, input logic [15:0] nine);
      write_reg(REG_TEMP, {16'd0, t});
      write_reg(REG_PRESS_A, a);
      write_reg(REG_PRESS_B, b);
      write_reg(REG_PRESS_9, {{48{nine[15]}}, nine});
   endtask

   task automatic send(input cmd_type cmd, input logic [19:0] raw_t,
                       input logic [19:0] raw_p);
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.raw_temperature <= raw_t;
      req.raw_pressure <= raw_p;
      do @(posedge clock); while (!req.ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic random_items(input int count);
      cmd_type cmd;
      logic [19:0] raw_t;
      logic [19:0] raw_p;
      for (int i = 0; i < count; i++) begin
         cmd = cmd_type'(($urandom_range(19) == 0) ? 3 : $urandom_range(2));
         if ($urandom_range(3) == 0) begin
            raw_t = 20'($urandom);
            raw_p = 20'($urandom);
         end else begin
            raw_t = 20'($urandom_range(400000, 600000));
            raw_p = 20'($urandom_range(250000, 450000));
         end
         send(cmd, raw_t, raw_p);
         if (i == count / 2 && $urandom_range(1) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.cmd <= CMD_BOTH;
      req.raw_temperature <= '0;
      req.raw_pressure <= '0;
      csr.valid <= 1'b0;
      csr.index <= REG_TEMP;
      csr.data <= '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero calibration: divisor is zero
      send(CMD_BOTH, 20'd519888, 20'd415148);
      send(CMD_PRESS, 20'd0, 20'hFFFFF);
      drain();

      // typical factory calibration
      load_cal({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
      send(CMD_BOTH, 20'd519888, 20'd415148);
      send(CMD_BOTH, 20'd0, 20'd0);
      send(CMD_BOTH, 20'hFFFFF, 20'hFFFFF);
      send(CMD_BOTH, 20'hAAAAA, 20'h55555);
      send(CMD_BOTH, 20'h55555, 20'hAAAAA);
      send(CMD_TEMP, 20'd500000, 20'hFFFFF);
      send(CMD_PRESS, 20'hFFFFF, 20'd300000);
      send(CMD_TEMP, 20'hFFFFF, 20'd0);
      send(CMD_PRESS, 20'd0, 20'd1);
      send(CMD_NONE, 20'hFFFFF, 20'hFFFFF);
      send(CMD_PRESS, 20'd0, 20'd415148);
      drain();

      // extremes to saturate fine temperature and temperature
      load_cal({16'h7FFF, 16'h8000, 16'd0}, 64'h7FFF_8000_7FFF_FFFF,
               64'h8000_7FFF_8000_7FFF, 16'h8000);
      send(CMD_BOTH, 20'hFFFFF, 20'd0);
      send(CMD_BOTH, 20'd0, 20'hFFFFF);
      send(CMD_TEMP, 20'd16, 20'd0);
      send(CMD_PRESS, 20'd0, 20'd12345);
      drain();
      load_cal(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               64'hFFFF_FFFF_FFFF_FFFF, 16'h7FFF);
      send(CMD_BOTH, 20'hFFFFF, 20'hFFFFF);
      send(CMD_BOTH, 20'd0, 20'd0);
      send(CMD_TEMP, 20'd1048560, 20'd0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 57;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 57;
            end
            default: begin
               send_idle_pct = 18;
               recv_stall_pct = 18;
            end
         endcase
         if (ph % 2 == 0) begin
            load_cal({16'hFC18 ^ 16'($urandom_range(63)), 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD643, 16'($urandom_range(20000, 40000))},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'($urandom_range(255))},
                     16'($urandom_range(8000)));
         end else begin
            load_cal(48'({$urandom, $urandom}), {$urandom, $urandom},
                     {$urandom, $urandom}, 16'($urandom));
         end
         random_items(145);
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      repeat (1000) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire
